// ===== sv/sfr_pkg.sv =====
// package with payload types, widths and register indexes of the find-and-replace block
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NBYTES  = WORD_W / BYTE_W;
  localparam int unsigned BIDX_W  = $clog2(NBYTES);
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 5;

  // register indexes
  localparam logic [1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [1:0] REG_PATTERN_BYTES = 2'd1;
  localparam logic [1:0] REG_SUBST_LEN     = 2'd2;
  localparam logic [1:0] REG_SUBST_BYTES   = 2'd3;

  // input transaction payload
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_text;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_empty;
    logic              is_last;
  } out_t;

  // byte i of a packed word, first byte in the lowest bits
  function automatic logic [BYTE_W-1:0] byte_at(logic [WORD_W-1:0] w, logic [BIDX_W-1:0] i);
    return w[i*BYTE_W +: BYTE_W];
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfr_in_if.sv =====
// valid/ready channel carrying input text bytes
`timescale 1ns / 1ps
`default_nettype none
interface sfr_in_if;
  logic          valid;
  logic          ready;
  sfr_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sfr_out_if.sv =====
// valid/ready channel carrying rewritten text bytes
`timescale 1ns / 1ps
`default_nettype none
interface sfr_out_if;
  logic          valid;
  logic          ready;
  sfr_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/stream_find_and_replace.sv =====
// streaming find-and-replace top level with config registers and result buffer
// Timing: the first result of a transaction is registered and appears in the cycle after it is accepted.
// Throughput: one input transaction per cycle while each gives at most one result and the receiver takes it;
//   a transaction with n results occupies the single result buffer until all n are taken, and the
//   next one is accepted in the cycle its last result is taken.
// Reset: rst_ni async active low clears the config registers, the prefix count and the buffer valid flag and index.
`timescale 1ns / 1ps
`default_nettype none
module stream_find_and_replace #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_SUBST   = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  sfr_in_if.sink                            in_i,
  sfr_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0]   pwdata,
  output logic      [sfr_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned BW = sfr_pkg::BYTE_W;
  localparam int unsigned LW = sfr_pkg::LEN_W;
  localparam int unsigned IW = sfr_pkg::BIDX_W;

  // configuration registers
  logic [LW-1:0]              plen_q, plen_d;
  logic [sfr_pkg::WORD_W-1:0] pbytes_q, pbytes_d;
  logic [LW-1:0]              slen_q, slen_d;
  logic [sfr_pkg::WORD_W-1:0] sbytes_q, sbytes_d;
  logic [1:0]                 reg_idx;
  logic                       cfg_wr;
  logic                       pat_wr;
  logic [LW-1:0]              wr_len;

  // matcher state and result buffer
  logic [LW-1:0]  k_q, k_d;
  logic           buf_valid_q, buf_valid_d;
  logic           buf_sub_q, buf_sub_d;
  logic           buf_empty_q, buf_empty_d;
  logic           buf_eot_q, buf_eot_d;
  logic [LW-1:0]  buf_cnt_q, buf_cnt_d;
  logic [LW-1:0]  buf_k_q, buf_k_d;
  logic [IW-1:0]  buf_idx_q, buf_idx_d;
  logic [BW-1:0]  buf_b_q, buf_b_d;

  logic                   in_fire, out_fire, last_fire;
  logic [BW-1:0]          pat [MAX_PATTERN];
  logic [MAX_PATTERN:1]   bd_tab [MAX_PATTERN];
  logic [MAX_PATTERN:1]   bd_sel;
  logic [LW-1:0]          k_eff, cnt, j_len, m_cnt, k_nxt;
  logic                   is_sub;
  logic [BW-1:0]          b_in;

  assign reg_idx = paddr[sfr_pkg::ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pat_wr  = cfg_wr && (reg_idx == sfr_pkg::REG_PATTERN_LEN ||
                              reg_idx == sfr_pkg::REG_PATTERN_BYTES);
  assign wr_len  = pwdata[LW-1:0];
  assign pready  = 1'b1;

  // register writes with length saturation
  always_comb begin
    plen_d   = plen_q;
    pbytes_d = pbytes_q;
    slen_d   = slen_q;
    sbytes_d = sbytes_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        sfr_pkg::REG_PATTERN_LEN:
          plen_d = (wr_len > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : wr_len;
        sfr_pkg::REG_PATTERN_BYTES: pbytes_d = pwdata;
        sfr_pkg::REG_SUBST_LEN:
          slen_d = (wr_len > LW'(MAX_SUBST)) ? LW'(MAX_SUBST) : wr_len;
        sfr_pkg::REG_SUBST_BYTES:   sbytes_d = pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      sfr_pkg::REG_PATTERN_LEN:   prdata = sfr_pkg::DATA_W'(plen_q);
      sfr_pkg::REG_PATTERN_BYTES: prdata = pbytes_q;
      sfr_pkg::REG_SUBST_LEN:     prdata = sfr_pkg::DATA_W'(slen_q);
      sfr_pkg::REG_SUBST_BYTES:   prdata = sbytes_q;
      default:                    prdata = '0;
    endcase
  end

  // pattern bytes as an array
  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      pat[p] = pbytes_q[p*BW +: BW];
    end
  end

  // border table: for a prefix of length kk, can a suffix of length jj-1
  // of that prefix be extended to a pattern prefix of length jj
  always_comb begin
    for (int kk = 0; kk < MAX_PATTERN; kk++) begin
      for (int jj = 1; jj <= MAX_PATTERN; jj++) begin
        bd_tab[kk][jj] = (jj <= kk + 1);
        if (jj <= kk + 1) begin
          for (int ii = 0; ii < jj - 1; ii++) begin
            if (pat[kk+1-jj+ii] != pat[ii]) begin
              bd_tab[kk][jj] = 1'b0;
            end
          end
        end
      end
    end
  end

  // handshakes
  assign out_fire  = buf_valid_q && out_o.ready;
  assign last_fire = out_fire && (LW'(buf_idx_q) + LW'(1) == buf_cnt_q);
  assign in_i.ready = !buf_valid_q || last_fire;
  assign in_fire   = in_i.valid && in_i.ready;
  assign b_in      = in_i.data.in_byte;

  // longest suffix of prefix plus new byte that is again a pattern prefix
  always_comb begin
    k_eff = (k_q >= plen_q) ? '0 : k_q;
    cnt   = k_eff + LW'(1);
    bd_sel = '0;
    for (int kk = 0; kk < MAX_PATTERN; kk++) begin
      if (k_eff == LW'(kk)) begin
        bd_sel = bd_tab[kk];
      end
    end
    j_len = '0;
    for (int jj = 1; jj <= MAX_PATTERN; jj++) begin
      if (bd_sel[jj] && b_in == pat[jj-1]) begin
        j_len = LW'(jj);
      end
    end
    // result descriptor and next prefix count
    if (plen_q == '0) begin
      is_sub = 1'b0;
      m_cnt  = LW'(1);
      k_nxt  = '0;
    end else if (j_len == plen_q) begin
      is_sub = 1'b1;
      m_cnt  = slen_q;
      k_nxt  = '0;
    end else begin
      is_sub = 1'b0;
      m_cnt  = in_i.data.end_of_text ? cnt : (cnt - j_len);
      k_nxt  = in_i.data.end_of_text ? '0 : j_len;
    end
    if (plen_q == '0) begin
      k_eff = '0;
    end
  end

  // buffer and state next values
  always_comb begin
    k_d         = k_q;
    buf_valid_d = buf_valid_q;
    buf_sub_d   = buf_sub_q;
    buf_empty_d = buf_empty_q;
    buf_eot_d   = buf_eot_q;
    buf_cnt_d   = buf_cnt_q;
    buf_k_d     = buf_k_q;
    buf_idx_d   = buf_idx_q;
    buf_b_d     = buf_b_q;
    if (out_fire) begin
      buf_idx_d = buf_idx_q + IW'(1);
    end
    if (last_fire) begin
      buf_valid_d = 1'b0;
    end
    if (in_fire) begin
      k_d = k_nxt;
      if (m_cnt != '0 || in_i.data.end_of_text) begin
        buf_valid_d = 1'b1;
        buf_sub_d   = is_sub;
        buf_empty_d = (m_cnt == '0);
        buf_eot_d   = in_i.data.end_of_text;
        buf_cnt_d   = (m_cnt == '0) ? LW'(1) : m_cnt;
        buf_k_d     = k_eff;
        buf_idx_d   = '0;
        buf_b_d     = b_in;
      end
    end
    if (pat_wr) begin
      k_d = '0;
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      pbytes_q    <= '0;
      slen_q      <= '0;
      sbytes_q    <= '0;
      k_q         <= '0;
      buf_valid_q <= 1'b0;
      buf_idx_q   <= '0;
    end else begin
      plen_q      <= plen_d;
      pbytes_q    <= pbytes_d;
      slen_q      <= slen_d;
      sbytes_q    <= sbytes_d;
      k_q         <= k_d;
      buf_valid_q <= buf_valid_d;
      buf_idx_q   <= buf_idx_d;
    end
  end

  // buffer payload
  always_ff @(posedge clk_i) begin
    buf_sub_q   <= buf_sub_d;
    buf_empty_q <= buf_empty_d;
    buf_eot_q   <= buf_eot_d;
    buf_cnt_q   <= buf_cnt_d;
    buf_k_q     <= buf_k_d;
    buf_b_q     <= buf_b_d;
  end

  // output byte selection
  always_comb begin
    out_o.valid = buf_valid_q;
    if (buf_empty_q) begin
      out_o.data.out_byte = '0;
    end else if (buf_sub_q) begin
      out_o.data.out_byte = sfr_pkg::byte_at(sbytes_q, buf_idx_q);
    end else if (LW'(buf_idx_q) < buf_k_q) begin
      out_o.data.out_byte = sfr_pkg::byte_at(pbytes_q, buf_idx_q);
    end else begin
      out_o.data.out_byte = buf_b_q;
    end
    out_o.data.is_empty = buf_empty_q;
    out_o.data.is_last  = buf_eot_q && (LW'(buf_idx_q) + LW'(1) == buf_cnt_q);
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (LW'(buf_idx_q) < buf_cnt_q))
    else $error("result index past count");

  a_prefix_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q == '0) || (k_q < plen_q))
    else $error("prefix count not below pattern length");

  a_eot_clears_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.end_of_text) |=> (k_q == '0))
    else $error("prefix count kept after end of text");

endmodule
`default_nettype wire

// ===== test/stream_find_and_replace_tb.sv =====
// testbench for the streaming find-and-replace block, directed and random text
`timescale 1ns / 1ps
module stream_find_and_replace_tb;
  import sfr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned PAT_MAX       = 8;
  localparam int unsigned SUB_MAX       = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;

  // rewrite predictor and store of expected output bytes
  class rewrite_board;
    logic [LEN_W-1:0]  pat_len;
    logic [WORD_W-1:0] pat_word;
    logic [LEN_W-1:0]  sub_len;
    logic [WORD_W-1:0] sub_word;
    int unsigned       prefix_cnt;
    out_t              expected_q[$];
    int unsigned       errors;

    function new();
      pat_len    = '0;
      pat_word   = '0;
      sub_len    = '0;
      sub_word   = '0;
      prefix_cnt = 0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [BYTE_W-1:0] pat_at(int unsigned i);
      return pat_word[i*BYTE_W +: BYTE_W];
    endfunction

    function out_t byte_item(logic [BYTE_W-1:0] b);
      out_t r;
      r.out_byte = b;
      r.is_empty = 1'b0;
      r.is_last  = 1'b0;
      return r;
    endfunction

    // register write as the block sees it; pattern writes drop the pending prefix
    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_PATTERN_LEN: begin
          pat_len    = (value[3:0] > PAT_MAX) ? LEN_W'(PAT_MAX) : value[3:0];
          prefix_cnt = 0;
        end
        REG_PATTERN_BYTES: begin
          pat_word   = value[WORD_W-1:0];
          prefix_cnt = 0;
        end
        REG_SUBST_LEN: begin
          sub_len = (value[3:0] > SUB_MAX) ? LEN_W'(SUB_MAX) : value[3:0];
        end
        REG_SUBST_BYTES: begin
          sub_word = value[WORD_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // expected output bytes for one accepted input transaction
    function void note(logic [BYTE_W-1:0] b, logic eot);
      logic [BYTE_W-1:0] seq [PAT_MAX+1];
      out_t burst[$];
      out_t tail;
      int unsigned k, cnt, j, i;
      bit ok;
      k = prefix_cnt;
      if (pat_len == 0) begin
        burst.push_back(byte_item(b));
        k = 0;
      end else begin
        if (k >= pat_len) k = 0;
        for (i = 0; i < k; i++) seq[i] = pat_at(i);
        seq[k] = b;
        cnt = k + 1;
        // longest suffix of the held bytes that is still a pattern prefix
        for (j = cnt; j > 0; j--) begin
          ok = 1'b1;
          for (i = 0; i < j; i++) begin
            if (seq[cnt-j+i] != pat_at(i)) begin
              ok = 1'b0;
              break;
            end
          end
          if (ok) break;
        end
        for (i = 0; i < cnt - j; i++) burst.push_back(byte_item(seq[i]));
        if (j == pat_len) begin
          for (i = 0; i < sub_len; i++) burst.push_back(byte_item(sub_word[i*BYTE_W +: BYTE_W]));
          k = 0;
        end else begin
          k = j;
        end
      end
      // end of text flushes the prefix and marks the last byte
      if (eot) begin
        for (i = 0; i < k; i++) burst.push_back(byte_item(pat_at(i)));
        k = 0;
        if (burst.size() == 0) begin
          tail          = byte_item(8'h00);
          tail.is_empty = 1'b1;
          tail.is_last  = 1'b1;
        end else begin
          tail         = burst.pop_back();
          tail.is_last = 1'b1;
        end
        burst.push_back(tail);
      end
      prefix_cnt = k;
      foreach (burst[n]) expected_q.push_back(burst[n]);
    endfunction

    // compare one output transaction with the oldest expectation
    function void check(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual byte %02h empty %0b last %0b",
                 $time, got.out_byte, got.is_empty, got.is_last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, got.out_byte);
          errors++;
        end
        if (got.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty, got.is_empty);
          errors++;
        end
        if (got.is_last !== want.is_last) begin
          $display("%0t: is_last expected %0b actual %0b", $time, want.is_last, got.is_last);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  rewrite_board board;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  bit           hold_req;
  int unsigned  hold_left;
  int unsigned  items_sent;
  int unsigned  cycle_count;

  stream_find_and_replace #(
    .MAX_PATTERN(PAT_MAX),
    .MAX_SUBST  (SUB_MAX)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("stream_find_and_replace_tb: errors");
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) board.check(out_if.data);
  end

  // offer one text byte, with random idle cycles in front
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {b, eot};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note(b, eot);
    items_sent++;
  endtask

  // stop offering until every expected byte is out, then let the pipeline settle
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup then access phase, then the bus is left idle
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // random pattern and substitute, often over a two-byte alphabet so that prefixes overlap
  task automatic random_config();
    logic [BYTE_W-1:0] sym_a, sym_b;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    int unsigned       r;
    sym_a = BYTE_W'($urandom_range(255));
    sym_b = BYTE_W'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 10) len = 0;
    else if (r < 25) len = LEN_W'($urandom_range(15, 9));
    else len = LEN_W'($urandom_range(8, 1));
    if ($urandom_range(99) < 75) begin
      for (int i = 0; i < 8; i++) word[i*BYTE_W +: BYTE_W] = $urandom_range(1) ? sym_a : sym_b;
    end else begin
      word = {$urandom, $urandom};
    end
    wait_drain();
    reg_write(REG_PATTERN_LEN, {$urandom, 28'($urandom_range(268435455)), len});
    reg_write(REG_PATTERN_BYTES, word);
    reg_write(REG_SUBST_LEN,
              {$urandom, 28'($urandom_range(268435455)), 4'($urandom_range(15))});
    reg_write(REG_SUBST_BYTES, {$urandom, $urandom});
  endtask

  // one text built mostly from pattern bytes, ending with end of text
  task automatic send_text(input int unsigned len);
    int unsigned       eff, walk, r;
    logic [BYTE_W-1:0] b;
    eff  = (board.pat_len == 0) ? 8 : board.pat_len;
    walk = 0;
    for (int unsigned n = 0; n < len; n++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        b    = board.pat_at(walk);
        walk = (walk + 1) % eff;
      end else if (r < 80) begin
        b = board.pat_at($urandom_range(eff - 1));
      end else begin
        b = BYTE_W'($urandom_range(255));
        walk = 0;
      end
      send_byte(b, n == len - 1);
      // occasional pattern rewrite in the middle of the text
      if (n != len - 1 && $urandom_range(99) < 3) begin
        wait_drain();
        if ($urandom_range(1)) reg_write(REG_PATTERN_BYTES, board.pat_word);
        else reg_write(REG_PATTERN_LEN, DATA_W'(board.pat_len));
      end
    end
  endtask

  // stimulus
  initial begin
    int unsigned phase_start;
    bit          hold_done;
    board         = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    items_sent    = 0;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass through with zero pattern length, byte extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // oversized lengths saturate; a full-length match gives the longest burst
    wait_drain();
    reg_write(REG_PATTERN_LEN, 64'hF);
    reg_write(REG_PATTERN_BYTES, '1);
    reg_write(REG_SUBST_LEN, 64'hF);
    reg_write(REG_SUBST_BYTES, 64'h0);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // empty substitute, then a pattern write mid-text drops the pending prefix
    wait_drain();
    reg_write(REG_PATTERN_LEN, 64'd3);
    reg_write(REG_PATTERN_BYTES, 64'h61_62_61);
    reg_write(REG_SUBST_LEN, 64'd0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    wait_drain();
    reg_write(REG_PATTERN_LEN, 64'd3);
    send_byte(8'h78, 1'b1);

    // end of text flushes a pending prefix
    wait_drain();
    reg_write(REG_SUBST_LEN, 64'd1);
    reg_write(REG_SUBST_BYTES, 64'h51);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);

    // match on the final byte with empty substitute leaves only the end marker
    wait_drain();
    reg_write(REG_SUBST_LEN, 64'd0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);

    // kmp fallback keeps the overlapping prefix
    wait_drain();
    reg_write(REG_PATTERN_BYTES, 64'h62_61_61);
    reg_write(REG_SUBST_LEN, 64'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);

    // random phases: sender idles lightly, then receiver lightly, then nobody
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 30) random_config();
        if ($urandom_range(99) < 5) wait_drain();
        if (ph == 2 && !hold_done && items_sent - phase_start > 40) begin
          // long receiver hold-off while the sender keeps offering
          hold_req  = 1'b1;
          hold_done = 1'b1;
          send_text(40);
        end else begin
          send_text($urandom_range(24, 1));
        end
      end
    end

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("stream_find_and_replace_tb: clean");
    end else begin
      $display("stream_find_and_replace_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sfr_pkg.sv
sv/sfr_in_if.sv
sv/sfr_out_if.sv
sv/stream_find_and_replace.sv
test/stream_find_and_replace_tb.sv
